// ===== hw/rtl/edfs_pkg.sv =====
package edfs_pkg;

  // Sizes of the scheduler
  localparam int NumTasks  = 3;
  localparam int TaskIdxW  = 2;
  localparam int TimeW     = 32;
  localparam int BudgetW   = 16;
  localparam int PeriodW   = 16;
  localparam int CountW    = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 40;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgPeriod0    = 3'd0,
    CfgPeriod1    = 3'd1,
    CfgPeriod2    = 3'd2,
    CfgBudget0    = 3'd3,
    CfgBudget1    = 3'd4,
    CfgBudget2    = 3'd5,
    CfgTasksInUse = 3'd6,
    CfgHorizon    = 3'd7
  } cfg_idx_e;

  // Configuration registers as one bundle
  typedef struct packed {
    logic [NumTasks-1:0][PeriodW-1:0] period;
    logic [NumTasks-1:0][BudgetW-1:0] budget;
    logic [CountW-1:0]                tasks_in_use;
    logic [TimeW-1:0]                 horizon;
  } cfg_t;

  // Per-task scheduling state
  typedef struct packed {
    logic [TimeW-1:0]   deadline;
    logic [BudgetW-1:0] budget;
    logic               ready;
  } task_t;

  // Whole scheduler state
  typedef struct packed {
    logic [TimeW-1:0]         cur_time;
    logic                     miss;
    task_t [NumTasks-1:0]     tasks;
  } sched_t;

  // One result beat
  typedef struct packed {
    logic [TaskIdxW-1:0] running_task;
    logic                idle_tick;
    logic                deadline_missed;
    logic                run_finished;
    logic [TimeW-1:0]    time_now;
  } result_t;

endpackage

// ===== hw/rtl/edfs_step.sv =====
module edfs_step (
  input  edfs_pkg::cfg_t    cfg_i,
  input  edfs_pkg::sched_t  state_i,
  input  logic              restart_i,
  output edfs_pkg::sched_t  state_o,
  output edfs_pkg::result_t result_o
);
  import edfs_pkg::*;

  // One scheduling tick: re-arm or detect a miss, drop empty tasks, pick earliest deadline
  always_comb begin
    sched_t                nxt;
    logic                  missed;
    logic                  found;
    logic [TaskIdxW-1:0]   run;
    logic [TimeW-1:0]      best;
    logic [NumTasks-1:0]   active;

    nxt    = state_i;
    missed = 1'b0;
    found  = 1'b0;
    run    = '0;
    best   = '0;

    for (int i = 0; i < NumTasks; i++) begin
      active[i] = cfg_i.tasks_in_use > CountW'(i);
    end

    if (restart_i) begin
      // Reload every task from its registers and clear time
      nxt.cur_time = '0;
      nxt.miss     = 1'b0;
      for (int i = 0; i < NumTasks; i++) begin
        nxt.tasks[i].deadline = TimeW'(cfg_i.period[i]);
        nxt.tasks[i].budget   = cfg_i.budget[i];
        nxt.tasks[i].ready    = 1'b1;
      end
    end else if (!state_i.miss && (state_i.cur_time < cfg_i.horizon)) begin
      // Walk the tasks in order; stop at the first one that is still ready at its deadline
      for (int i = 0; i < NumTasks; i++) begin
        if (active[i] && !missed && (state_i.tasks[i].deadline == state_i.cur_time)) begin
          if (state_i.tasks[i].ready) begin
            missed = 1'b1;
          end else begin
            nxt.tasks[i].deadline = state_i.tasks[i].deadline + TimeW'(cfg_i.period[i]);
            nxt.tasks[i].ready    = 1'b1;
            nxt.tasks[i].budget   = cfg_i.budget[i];
          end
        end
      end

      if (missed) begin
        nxt.miss = 1'b1;
      end else begin
        // Drop tasks with no budget left, then select the earliest deadline
        for (int i = 0; i < NumTasks; i++) begin
          if (active[i] && nxt.tasks[i].ready && (nxt.tasks[i].budget == '0)) begin
            nxt.tasks[i].ready = 1'b0;
          end
          if (active[i] && nxt.tasks[i].ready && (!found || (nxt.tasks[i].deadline < best))) begin
            found = 1'b1;
            best  = nxt.tasks[i].deadline;
            run   = TaskIdxW'(i);
          end
        end

        // Charge one tick to the running task
        for (int i = 0; i < NumTasks; i++) begin
          if (found && (run == TaskIdxW'(i))) begin
            nxt.tasks[i].budget = nxt.tasks[i].budget - BudgetW'(1);
            if (nxt.tasks[i].budget == '0) begin
              nxt.tasks[i].ready = 1'b0;
            end
          end
        end

        nxt.cur_time = state_i.cur_time + TimeW'(1);
      end
    end

    state_o                  = nxt;
    result_o.running_task    = found ? run : '0;
    result_o.idle_tick       = !found;
    result_o.deadline_missed = nxt.miss;
    result_o.run_finished    = nxt.cur_time >= cfg_i.horizon;
    result_o.time_now        = nxt.cur_time;
  end

endmodule

// ===== hw/rtl/edf_periodic_task_scheduler_unit.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid_i/tready_o      tdata[0] restart
// m_axis    out  m_axis_tvalid_o/tready_i      tdata: running_task, idle_tick,
//                                              deadline_missed, run_finished, time_now
// cfg       in   cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// One tick per cycle unless input tready is low: the whole EDF step (deadline
// compares, re-arm, minimum over three deadlines) sits between the state registers
// and the result register, so a result is registered when its tick beat is accepted.
// An output register plus a skid register let one new beat enter while a result
// waits; input tready drops only when both hold results.
// Reset loads periods 1, budgets 0, one task in use, horizon 1, and the reloaded
// schedule state; no clearing pass.
module edf_periodic_task_scheduler_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [edfs_pkg::InDataW-1:0]       s_axis_tdata_i,  // [0] restart, [7:1] zero
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [1:0] running_task, [2] idle_tick, [3] deadline_missed, [4] run_finished,
  // [36:5] time_now, [39:37] zero
  output logic [edfs_pkg::OutDataW-1:0]      m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [edfs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [edfs_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import edfs_pkg::*;

  cfg_t    cfg_q;
  sched_t  state_q, state_d;
  result_t step_res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_acc, out_take, restart;

  assign restart         = s_axis_tdata_i[0];
  assign s_axis_tready_o = !skid_valid_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = out_valid_q && m_axis_tready_i;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTasks; i++) begin
        cfg_q.period[i] <= PeriodW'(1);
        cfg_q.budget[i] <= '0;
      end
      cfg_q.tasks_in_use <= CountW'(1);
      cfg_q.horizon      <= TimeW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPeriod0:    cfg_q.period[0]    <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriod1:    cfg_q.period[1]    <= cfg_wdata_i[PeriodW-1:0];
        CfgPeriod2:    cfg_q.period[2]    <= cfg_wdata_i[PeriodW-1:0];
        CfgBudget0:    cfg_q.budget[0]    <= cfg_wdata_i[BudgetW-1:0];
        CfgBudget1:    cfg_q.budget[1]    <= cfg_wdata_i[BudgetW-1:0];
        CfgBudget2:    cfg_q.budget[2]    <= cfg_wdata_i[BudgetW-1:0];
        CfgTasksInUse: cfg_q.tasks_in_use <= cfg_wdata_i[CountW-1:0];
        CfgHorizon:    cfg_q.horizon      <= cfg_wdata_i[TimeW-1:0];
        default:       cfg_q              <= cfg_q;
      endcase
    end
  end

  edfs_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .restart_i (restart),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  // Advance the schedule state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cur_time <= '0;
      state_q.miss     <= 1'b0;
      for (int i = 0; i < NumTasks; i++) begin
        state_q.tasks[i].deadline <= TimeW'(1);
        state_q.tasks[i].budget   <= '0;
        state_q.tasks[i].ready    <= 1'b1;
      end
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= step_res;
      end
    end else if (in_acc) begin
      skid_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.time_now, out_q.run_finished,
                            out_q.deadline_missed, out_q.idle_tick, out_q.running_task};

  // Skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // Time moves only on an accepted beat
  a_time_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(state_q.cur_time))
    else $error("time changed without an input beat");

  // Miss flag is sticky until a restart
  a_miss_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.miss && !(in_acc && restart) |=> state_q.miss)
    else $error("miss flag cleared without restart");

  // Ticks after a miss leave time alone
  a_miss_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.miss && in_acc && !restart |=> $stable(state_q.cur_time))
    else $error("time advanced after a deadline miss");

endmodule

// ===== bench/edf_periodic_task_scheduler_unit_tb.sv =====
module edf_periodic_task_scheduler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edfs_pkg::*;

  localparam int RandItems  = 950;
  localparam int HoldCycles = 60;
  localparam int ScriptLen  = 42;

  // One line of the directed script: a register write or an input beat
  typedef struct packed {
    logic                is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] wdata;
    logic                restart;
    logic                typed;
    result_t             want;
  } script_row_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;   // [0] restart, [7:1] zero
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [1:0] running_task, [2] idle_tick, [3] deadline_missed, [4] run_finished,
  // [36:5] time_now, [39:37] zero
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;

  // Shadow copy of the configuration registers
  logic [PeriodW-1:0]  period_c [NumTasks];
  logic [BudgetW-1:0]  budget_c [NumTasks];
  logic [CountW-1:0]   ntask_c;
  logic [TimeW-1:0]    horizon_c;

  // Shadow copy of the schedule state
  logic [TimeW-1:0]    now_m;
  logic [TimeW-1:0]    deadline_m [NumTasks];
  logic [BudgetW-1:0]  left_m [NumTasks];
  logic                ready_m [NumTasks];
  logic                miss_m;
  logic                step_live;

  result_t             pending_results [$];
  script_row_t         script [ScriptLen];

  int fails         = 0;
  int results_seen  = 0;
  int miss_beats    = 0;
  int beats_sent    = 0;
  int live_items    = 0;
  int settings      = 0;
  int burst_left    = 1;
  int hold_requests = 0;
  int holds_served  = 0;

  edf_periodic_task_scheduler_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reload deadlines, budgets and time from the shadow registers
  function automatic void reload_schedule();
    int i;
    now_m  = '0;
    miss_m = 1'b0;
    for (i = 0; i < NumTasks; i++) begin
      deadline_m[i] = TimeW'(period_c[i]);
      left_m[i]     = budget_c[i];
      ready_m[i]    = 1'b1;
    end
  endfunction

  // Advance the shadow scheduler by one input beat and return its result
  function automatic result_t edf_step(input logic restart);
    result_t          r;
    int               n;
    int               i;
    int               run;
    logic             idle;
    logic             missed;
    logic             found;
    logic [TimeW-1:0] best;
    n         = int'(ntask_c);
    run       = 0;
    idle      = 1'b1;
    missed    = 1'b0;
    found     = 1'b0;
    best      = '0;
    step_live = 1'b1;
    if (n > NumTasks) n = NumTasks;
    if (restart) begin
      reload_schedule();
    end else if (!miss_m && now_m < horizon_c) begin
      // Check deadlines in index order; stop at the first miss
      for (i = 0; i < n; i++) begin
        if (!missed && deadline_m[i] == now_m) begin
          if (ready_m[i]) begin
            missed = 1'b1;
          end else begin
            deadline_m[i] = deadline_m[i] + TimeW'(period_c[i]);
            ready_m[i]    = 1'b1;
            left_m[i]     = budget_c[i];
          end
        end
      end
      if (missed) begin
        miss_m = 1'b1;
      end else begin
        // Drop exhausted tasks and pick the earliest deadline
        for (i = 0; i < n; i++) begin
          if (ready_m[i] && left_m[i] == '0) ready_m[i] = 1'b0;
          if (ready_m[i] && (!found || deadline_m[i] < best)) begin
            found = 1'b1;
            best  = deadline_m[i];
            run   = i;
          end
        end
        if (found) begin
          idle        = 1'b0;
          left_m[run] = left_m[run] - 1'b1;
          if (left_m[run] == '0) ready_m[run] = 1'b0;
        end
        now_m = now_m + 1'b1;
      end
    end else begin
      step_live = 1'b0;
    end
    r.running_task    = idle ? '0 : TaskIdxW'(run);
    r.idle_tick       = idle;
    r.deadline_missed = miss_m;
    r.run_finished    = (now_m >= horizon_c);
    r.time_now        = now_m;
    return r;
  endfunction

  function automatic script_row_t reg_row(input cfg_idx_e idx, input logic [CfgDataW-1:0] v);
    script_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.wdata  = v;
    return r;
  endfunction

  function automatic script_row_t beat_row(input logic restart);
    script_row_t r;
    r         = '0;
    r.restart = restart;
    return r;
  endfunction

  function automatic script_row_t known_row(input logic restart, input logic [1:0] run,
                                            input logic idle, input logic miss,
                                            input logic fin, input logic [TimeW-1:0] t);
    script_row_t r;
    r                      = '0;
    r.restart              = restart;
    r.typed                = 1'b1;
    r.want.running_task    = run;
    r.want.idle_tick       = idle;
    r.want.deadline_missed = miss;
    r.want.run_finished    = fin;
    r.want.time_now        = t;
    return r;
  endfunction

  // Either zero or random bits above a narrow register
  function automatic logic [CfgDataW-1:0] upper_noise();
    return ($urandom_range(0, 1) == 1) ? CfgDataW'($urandom) : '0;
  endfunction

  // Offer one beat, hold it until accepted, then log its expected result
  task automatic push_item(input logic restart, input logic typed, input result_t want);
    result_t pred;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW-1){1'b0}}, restart};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = edf_step(restart);
    pending_results.push_back(typed ? want : pred);
    beats_sent++;
    if (step_live) live_items++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Stop offering and wait until every result is back and the pipe is quiet
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write one register; the caller lowers the write enable after a batch
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CfgPeriod0:    period_c[0] = data[PeriodW-1:0];
      CfgPeriod1:    period_c[1] = data[PeriodW-1:0];
      CfgPeriod2:    period_c[2] = data[PeriodW-1:0];
      CfgBudget0:    budget_c[0] = data[BudgetW-1:0];
      CfgBudget1:    budget_c[1] = data[BudgetW-1:0];
      CfgBudget2:    budget_c[2] = data[BudgetW-1:0];
      CfgTasksInUse: ntask_c     = data[CountW-1:0];
      CfgHorizon:    horizon_c   = data[TimeW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Draw a fresh task set, mostly small and schedulable, sometimes extreme
  task automatic pick_schedule();
    logic [PeriodW-1:0]  per [NumTasks];
    logic [BudgetW-1:0]  bud;
    logic [CfgDataW-1:0] noise;
    logic [TimeW-1:0]    hz;
    int                  i;
    int                  roll;
    int                  lim;
    settle();
    for (i = 0; i < NumTasks; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)       per[i] = '0;
      else if (roll < 9)  per[i] = '1;
      else if (roll < 13) per[i] = PeriodW'($urandom_range(13, 65535));
      else                per[i] = PeriodW'($urandom_range(1, 12));
      noise = upper_noise();
      write_reg(cfg_idx_e'(CfgPeriod0 + i), {noise[CfgDataW-1:PeriodW], per[i]});
    end
    for (i = 0; i < NumTasks; i++) begin
      roll = $urandom_range(0, 99);
      lim  = (per[i] > 12) ? 12 : int'(per[i]);
      if (roll < 4)       bud = '1;
      else if (roll < 8)  bud = BudgetW'($urandom);
      else if (roll < 40) bud = BudgetW'($urandom_range(0, lim));
      else                bud = BudgetW'($urandom_range(0, lim / 3 + 1));
      noise = upper_noise();
      write_reg(cfg_idx_e'(CfgBudget0 + i), {noise[CfgDataW-1:BudgetW], bud});
    end
    noise = upper_noise();
    roll  = $urandom_range(0, 99);
    write_reg(CfgTasksInUse, {noise[CfgDataW-1:CountW],
                              (roll < 70) ? 2'd3 : CountW'($urandom_range(0, 3))});
    roll = $urandom_range(0, 99);
    if (roll < 10)      hz = '1;
    else if (roll < 15) hz = TimeW'($urandom_range(0, 2));
    else                hz = TimeW'($urandom_range(8, 120));
    write_reg(CfgHorizon, hz);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic cmp_field(input string name, input logic [TimeW-1:0] want,
                           input logic [TimeW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.running_task    = m_axis_tdata_o[1:0];
      got.idle_tick       = m_axis_tdata_o[2];
      got.deadline_missed = m_axis_tdata_o[3];
      got.run_finished    = m_axis_tdata_o[4];
      got.time_now        = m_axis_tdata_o[36:5];
      results_seen++;
      if (got.deadline_missed) miss_beats++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata_o);
        fails++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("running_task", want.running_task, got.running_task);
        cmp_field("idle_tick", want.idle_tick, got.idle_tick);
        cmp_field("deadline_missed", want.deadline_missed, got.deadline_missed);
        cmp_field("run_finished", want.run_finished, got.run_finished);
        cmp_field("time_now", want.time_now, got.time_now);
      end
    end
  end

  // Stall the result side in stretches, with long hold-offs on request
  initial begin : result_sink
    int stretch;
    int stall_pct;
    stretch   = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        holds_served++;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(8, 64);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      stretch--;
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus: directed script, then random task sets
  initial begin : stimulus
    int   k;
    int   j;
    int   len;
    int   quiet;
    logic cfg_open;

    for (k = 0; k < NumTasks; k++) begin
      period_c[k] = PeriodW'(1);
      budget_c[k] = '0;
    end
    ntask_c   = CountW'(1);
    horizon_c = TimeW'(1);
    reload_schedule();
    cfg_open  = 1'b0;

    script = '{
      // reset values: zero budget, then a tick at the horizon, then restart
      known_row(1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 32'd1),
      known_row(1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 32'd1),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0),
      // zero period misses at once; the next tick is ignored
      reg_row(CfgPeriod0, 32'd0),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0),
      known_row(1'b0, 2'd0, 1'b1, 1'b1, 1'b0, 32'd0),
      known_row(1'b0, 2'd0, 1'b1, 1'b1, 1'b0, 32'd0),
      // no task in use: every tick idle
      reg_row(CfgTasksInUse, 32'd0),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0),
      known_row(1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 32'd1),
      // three tasks near full load
      reg_row(CfgPeriod0, 32'd4),
      reg_row(CfgPeriod1, 32'd6),
      reg_row(CfgPeriod2, 32'd8),
      reg_row(CfgBudget0, 32'd1),
      reg_row(CfgBudget1, 32'd2),
      reg_row(CfgBudget2, 32'd3),
      reg_row(CfgTasksInUse, 32'd3),
      reg_row(CfgHorizon, 32'd24),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0),
      beat_row(1'b0), beat_row(1'b0), beat_row(1'b0), beat_row(1'b0), beat_row(1'b0),
      beat_row(1'b0), beat_row(1'b0), beat_row(1'b0), beat_row(1'b0), beat_row(1'b0),
      // largest periods, budgets and horizon: equal deadlines go to task zero
      reg_row(CfgPeriod0, 32'hFFFF),
      reg_row(CfgPeriod1, 32'hFFFF),
      reg_row(CfgPeriod2, 32'hFFFF),
      reg_row(CfgBudget0, 32'hFFFF),
      reg_row(CfgBudget1, 32'hFFFF),
      reg_row(CfgBudget2, 32'hFFFF),
      reg_row(CfgHorizon, 32'hFFFF_FFFF),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b0, 32'd0),
      known_row(1'b0, 2'd0, 1'b0, 1'b0, 1'b0, 32'd1),
      beat_row(1'b0),
      // zero horizon: finished from the start, ticks ignored
      reg_row(CfgHorizon, 32'd0),
      known_row(1'b1, 2'd0, 1'b1, 1'b0, 1'b1, 32'd0),
      known_row(1'b0, 2'd0, 1'b1, 1'b0, 1'b1, 32'd0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed script
    for (k = 0; k < ScriptLen; k++) begin
      if (script[k].is_cfg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
          settings++;
        end
        write_reg(script[k].idx, script[k].wdata);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        push_item(script[k].restart, script[k].typed, script[k].want);
      end
    end

    // Random task sets: mostly restart then a run of ticks, with stray restarts
    live_items = 0;
    while (live_items < RandItems) begin
      pick_schedule();
      if (settings == 6 || settings == 14) hold_requests++;
      if ($urandom_range(0, 99) < 85) push_item(1'b1, 1'b0, '0);
      len   = $urandom_range(15, 90);
      quiet = 0;
      for (j = 0; j < len && quiet < 3; j++) begin
        push_item($urandom_range(0, 99) < 4, 1'b0, '0);
        if (!step_live) quiet++;
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    $display("checked %0d result beats from %0d input beats over %0d task settings",
             results_seen, beats_sent, settings);
    $display("%0d result beats carried the deadline miss flag", miss_beats);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("[edf_periodic_task_scheduler_unit] OK");
    end else begin
      $display("[edf_periodic_task_scheduler_unit] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #5ms;
    $display("[edf_periodic_task_scheduler_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/edfs_pkg.sv
hw/rtl/edfs_step.sv
hw/rtl/edf_periodic_task_scheduler_unit.sv
bench/edf_periodic_task_scheduler_unit_tb.sv
